>>> rtl/core/gclp_pkg.sv
// Shared types and constants of the G-code line character parser.
`default_nettype none

package gclp_pkg;

   // Characters with a special meaning to the parser.
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_BIT    = 8'h20;
   localparam logic [6:0] CHAR_M      = 7'h4D;

   // Mantissa of the M command that switches to free text.
   localparam int M_TEXT_CODE = 117;

   // Positions in the seen mask.
   localparam int SEEN_W = 13;
   localparam int SEEN_G = 0;
   localparam int SEEN_M = 1;
   localparam int SEEN_X = 2;
   localparam int SEEN_Y = 3;
   localparam int SEEN_Z = 4;
   localparam int SEEN_E = 5;
   localparam int SEEN_F = 6;
   localparam int SEEN_S = 7;
   localparam int SEEN_P = 8;
   localparam int SEEN_T = 9;
   localparam int SEEN_I = 10;
   localparam int SEEN_J = 11;
   localparam int SEEN_R = 12;

   localparam logic [SEEN_W-1:0] SEEN_ARC_MASK = 13'h1C00;
   localparam logic [SEEN_W-1:0] SEEN_CMD_MASK = 13'h0203;
   localparam logic [SEEN_W-1:0] SEEN_T_MASK   = 13'h0200;

   // Depth of the queue between the classifier and the executing part.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // One classified character.
   typedef struct packed {
      logic              is_digit;
      logic [3:0]        digit;
      logic              is_letter;   // A to Z after folding, or '*'
      logic [6:0]        letter;
      logic [SEEN_W-1:0] seen;        // seen bit of the letter, arc letters not yet gated
      logic              is_point;
      logic              is_minus;
      logic              is_open;     // '[' or ';'
      logic              is_close;    // ']'
      logic              is_eol;      // CR or LF
   } char_class_type;

endpackage

`default_nettype wire

>>> rtl/core/gclp_front.sv
// Classifier: folds case and sorts each received byte into character classes.
`default_nettype none

module gclp_front (
   input  wire logic [7:0]               req_text_byte,
   output gclp_pkg::char_class_type      item
);

   logic [7:0] up_byte;
   logic       is_lower;

   always_comb begin
      is_lower = (req_text_byte >= gclp_pkg::CHAR_LOW_A) &&
                 (req_text_byte <= gclp_pkg::CHAR_LOW_Z);
      up_byte  = is_lower ? (req_text_byte & ~gclp_pkg::CASE_BIT) : req_text_byte;

      // Folding only touches letters, and in text mode only ']' and line ends
      // matter, so the folded byte serves both modes.
      item.is_digit  = (up_byte >= gclp_pkg::CHAR_ZERO) && (up_byte <= gclp_pkg::CHAR_NINE);
      item.digit     = up_byte[3:0];
      item.is_letter = ((up_byte >= gclp_pkg::CHAR_UP_A) && (up_byte <= gclp_pkg::CHAR_UP_Z))
                       || (up_byte == gclp_pkg::CHAR_STAR);
      item.letter    = up_byte[6:0];
      item.is_point  = (up_byte == gclp_pkg::CHAR_POINT);
      item.is_minus  = (up_byte == gclp_pkg::CHAR_MINUS);
      item.is_open   = (up_byte == gclp_pkg::CHAR_LBRACK) || (up_byte == gclp_pkg::CHAR_SEMI);
      item.is_close  = (up_byte == gclp_pkg::CHAR_RBRACK);
      item.is_eol    = (up_byte == gclp_pkg::CHAR_LF) || (up_byte == gclp_pkg::CHAR_CR);

      item.seen = '0;
      unique case (up_byte)
         "G":     item.seen[gclp_pkg::SEEN_G] = 1'b1;
         "M":     item.seen[gclp_pkg::SEEN_M] = 1'b1;
         "X":     item.seen[gclp_pkg::SEEN_X] = 1'b1;
         "Y":     item.seen[gclp_pkg::SEEN_Y] = 1'b1;
         "Z":     item.seen[gclp_pkg::SEEN_Z] = 1'b1;
         "E":     item.seen[gclp_pkg::SEEN_E] = 1'b1;
         "F":     item.seen[gclp_pkg::SEEN_F] = 1'b1;
         "S":     item.seen[gclp_pkg::SEEN_S] = 1'b1;
         "P":     item.seen[gclp_pkg::SEEN_P] = 1'b1;
         "T":     item.seen[gclp_pkg::SEEN_T] = 1'b1;
         "I":     item.seen[gclp_pkg::SEEN_I] = 1'b1;
         "J":     item.seen[gclp_pkg::SEEN_J] = 1'b1;
         "R":     item.seen[gclp_pkg::SEEN_R] = 1'b1;
         default: item.seen = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/gclp_queue.sv
// Short queue of classified characters between the classifier and the executing part.
`default_nettype none

module gclp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   input  wire gclp_pkg::char_class_type push_item,
   output logic                         pop_valid,
   input  wire logic                    pop_ready,
   output gclp_pkg::char_class_type     pop_item
);

   gclp_pkg::char_class_type entry_ff [gclp_pkg::QUEUE_DEPTH];

   logic [gclp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gclp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gclp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                              push, pop;

   assign push_ready = (count_ff != gclp_pkg::QUEUE_CNT_W'(gclp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/gclp_back.sv
// Executing part: line state, number accumulation and the result slot.
`default_nettype none

module gclp_back #(
   parameter int MAX_FRAC_DIGITS = 4,
   parameter int MANTISSA_BITS   = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,
   input  wire logic                     q_valid,
   output logic                          q_ready,
   input  wire gclp_pkg::char_class_type q_item,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_result_kind,
   output logic [6:0]                    rsp_field_letter,
   output logic                          rsp_value_negative,
   output logic [31:0]                   rsp_value_mantissa,
   output logic [2:0]                    rsp_point_code,
   output logic [12:0]                   rsp_seen_mask,
   output logic                          rsp_has_command,
   output logic                          rsp_last_of_run
);

   localparam int PC_W = $clog2(MAX_FRAC_DIGITS + 2);
   localparam logic [PC_W-1:0] PC_LIMIT = PC_W'(MAX_FRAC_DIGITS + 1);

   localparam int SW = gclp_pkg::SEEN_W;

   logic                     arc_enable_ff;

   // Line state.
   logic [6:0]               letter_ff, letter_in;
   logic [SW-1:0]            cur_seen_ff, cur_seen_in;
   logic                     sign_ff, sign_in;
   logic [MANTISSA_BITS-1:0] mant_ff, mant_in;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic [SW-1:0]            seen_ff, seen_in;
   logic                     in_string_ff, in_string_in;

   // Result slot: a field result and a line end result that follows it.
   logic                     f_v_ff, e_v_ff;
   logic [6:0]               f_letter_ff;
   logic                     f_neg_ff;
   logic [31:0]              f_mant_ff;
   logic [2:0]               f_pt_ff;
   logic [SW-1:0]            e_mask_ff;
   logic                     e_cmd_ff;

   logic                     slot_free, pop, take;
   logic                     emit_f, emit_e;
   logic [SW-1:0]            gate, char_seen;

   // A new character may enter the slot once it is empty or its only result leaves now.
   assign slot_free = !(f_v_ff || e_v_ff) || (rsp_ready && (f_v_ff ^ e_v_ff));
   assign q_ready   = slot_free;
   assign pop       = q_valid && slot_free;
   assign take      = rsp_valid && rsp_ready;
   assign gate      = arc_enable_ff ? '1 : ~gclp_pkg::SEEN_ARC_MASK;
   assign char_seen = q_item.seen & gate;

   always_comb begin
      letter_in    = letter_ff;
      cur_seen_in  = cur_seen_ff;
      sign_in      = sign_ff;
      mant_in      = mant_ff;
      pc_in        = pc_ff;
      seen_in      = seen_ff;
      in_string_in = in_string_ff;
      emit_f       = 1'b0;
      emit_e       = 1'b0;

      if (pop) begin
         if (!in_string_ff) begin
            // Any byte other than a digit or a point ends an open value field.
            emit_f = (letter_ff != '0) && !q_item.is_digit && !q_item.is_point &&
                     (|(cur_seen_ff & gate & ~gclp_pkg::SEEN_T_MASK));
            if (emit_f && (letter_ff == gclp_pkg::CHAR_M) &&
                (mant_ff == MANTISSA_BITS'(gclp_pkg::M_TEXT_CODE))) begin
               in_string_in = 1'b1;
            end
            if (q_item.is_letter) begin
               letter_in   = q_item.letter;
               cur_seen_in = q_item.seen;
               sign_in     = 1'b0;
               mant_in     = '0;
               pc_in       = '0;
            end
            if (q_item.is_digit) begin
               if (pc_ff < PC_LIMIT) begin
                  mant_in = (mant_ff << 3) + (mant_ff << 1) + MANTISSA_BITS'(q_item.digit);
                  if (pc_ff != '0) begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
            end else if (char_seen != '0) begin
               seen_in = seen_ff | char_seen;
            end else if (q_item.is_open) begin
               in_string_in = 1'b1;
            end else if (q_item.is_minus) begin
               sign_in = 1'b1;
               mant_in = '0;
               pc_in   = '0;
            end else if (q_item.is_point && (pc_ff == '0)) begin
               pc_in = PC_W'(1);
            end
         end else if (q_item.is_close) begin
            in_string_in = 1'b0;
         end

         if (q_item.is_eol) begin
            emit_e       = 1'b1;
            seen_in      = '0;
            in_string_in = 1'b0;
            letter_in    = '0;
            cur_seen_in  = '0;
            sign_in      = 1'b0;
            mant_in      = '0;
            pc_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arc_enable_ff <= 1'b0;
         letter_ff     <= '0;
         cur_seen_ff   <= '0;
         sign_ff       <= 1'b0;
         mant_ff       <= '0;
         pc_ff         <= '0;
         seen_ff       <= '0;
         in_string_ff  <= 1'b0;
         f_v_ff        <= 1'b0;
         e_v_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            arc_enable_ff <= csr_wr_data;
         end
         letter_ff    <= letter_in;
         cur_seen_ff  <= cur_seen_in;
         sign_ff      <= sign_in;
         mant_ff      <= mant_in;
         pc_ff        <= pc_in;
         seen_ff      <= seen_in;
         in_string_ff <= in_string_in;
         if (pop) begin
            f_v_ff <= emit_f;
            e_v_ff <= emit_e;
         end else if (take) begin
            if (f_v_ff) begin
               f_v_ff <= 1'b0;
            end else begin
               e_v_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit_f) begin
         f_letter_ff <= letter_ff;
         f_neg_ff    <= sign_ff;
         f_mant_ff   <= 32'(mant_ff);
         f_pt_ff     <= 3'(pc_ff);
      end
      if (pop && emit_e) begin
         e_mask_ff <= seen_ff;
         e_cmd_ff  <= |(seen_ff & gclp_pkg::SEEN_CMD_MASK);
      end
   end

   // The field result goes first; the line end follows it.
   always_comb begin
      rsp_valid          = f_v_ff || e_v_ff;
      rsp_result_kind    = !f_v_ff;
      rsp_field_letter   = f_v_ff ? f_letter_ff : '0;
      rsp_value_negative = f_v_ff ? f_neg_ff : 1'b0;
      rsp_value_mantissa = f_v_ff ? f_mant_ff : '0;
      rsp_point_code     = f_v_ff ? f_pt_ff : '0;
      rsp_seen_mask      = f_v_ff ? '0 : e_mask_ff;
      rsp_has_command    = f_v_ff ? 1'b0 : e_cmd_ff;
      rsp_last_of_run    = f_v_ff ? !e_v_ff : 1'b1;
   end

   a_line_cleared: assert property (@(posedge clock) disable iff (reset)
      pop && q_item.is_eol |=> (seen_ff == '0) && !in_string_ff && (letter_ff == '0) &&
                               (pc_ff == '0) && !sign_ff)
      else $error("line state not cleared after a line end");

   a_no_field_no_letter_bits: assert property (@(posedge clock) disable iff (reset)
      (letter_ff == '0) |-> (cur_seen_ff == '0))
      else $error("letter bits present without an open field");

   a_point_count_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_LIMIT)
      else $error("fraction digit count beyond its limit");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      f_v_ff && e_v_ff && rsp_ready |=> !f_v_ff && e_v_ff)
      else $error("line end result lost after its field result");

endmodule

`default_nettype wire

>>> rtl/core/gcode_line_char_parser.sv
// Top level of the G-code line character parser.
`default_nettype none

// Takes one G-code character per transfer on the req_ channel and returns raw
// field values (sign, decimal mantissa, point code) and end-of-line summaries on
// the rsp_ channel. A character is taken every cycle while the four-entry
// character queue has room; the executing part handles one character per cycle
// while its result slot is free and emits at most one result per cycle, so a
// character that ends a field and the line at once (two results) holds the
// slot until both are taken. The user must write the arc_enable register through
// csr_wr_en and csr_wr_data only while idle; the block does not enforce this.
module gcode_line_char_parser #(
   parameter int MAX_FRAC_DIGITS = 4,
   parameter int MANTISSA_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [6:0]       rsp_field_letter,
   output logic             rsp_value_negative,
   output logic [31:0]      rsp_value_mantissa,
   output logic [2:0]       rsp_point_code,
   output logic [12:0]      rsp_seen_mask,
   output logic             rsp_has_command,
   output logic             rsp_last_of_run
);

   gclp_pkg::char_class_type front_item;
   gclp_pkg::char_class_type q_item;
   logic                     q_valid;
   logic                     q_ready;

   gclp_front u_front (
      .req_text_byte (req_text_byte),
      .item          (front_item)
   );

   gclp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   gclp_back #(
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
      .MANTISSA_BITS   (MANTISSA_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_valid            (q_valid),
      .q_ready            (q_ready),
      .q_item             (q_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_field_letter   (rsp_field_letter),
      .rsp_value_negative (rsp_value_negative),
      .rsp_value_mantissa (rsp_value_mantissa),
      .rsp_point_code     (rsp_point_code),
      .rsp_seen_mask      (rsp_seen_mask),
      .rsp_has_command    (rsp_has_command),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> test/gcode_line_char_parser_tb.sv
// Self-checking testbench for the G-code line character parser.
`default_nettype none

module gcode_line_char_parser_tb;

   localparam int FRAC_LIMIT   = 4;
   localparam int MANT_BITS    = 32;
   localparam int DRAIN_CYCLES = 20;
   localparam int QUIET_LIMIT  = 1000;

   typedef struct packed {
      logic                        kind;
      logic [6:0]                  letter;
      logic                        negative;
      logic [31:0]                 mantissa;
      logic [2:0]                  point;
      logic [gclp_pkg::SEEN_W-1:0] seen;
      logic                        command;
      logic                        last_of_run;
   } parse_result_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_text_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [6:0]  rsp_field_letter;
   logic        rsp_value_negative;
   logic [31:0] rsp_value_mantissa;
   logic [2:0]  rsp_point_code;
   logic [12:0] rsp_seen_mask;
   logic        rsp_has_command;
   logic        rsp_last_of_run;

   // Predicted parser state.
   logic [7:0]                  open_letter = '0;
   logic                        num_negative = 1'b0;
   logic [31:0]                 num_mantissa = '0;
   logic [3:0]                  frac_count = '0;
   logic [gclp_pkg::SEEN_W-1:0] seen_flags = '0;
   logic                        in_text = 1'b0;
   logic                        arc_mode = 1'b0;

   parse_result_type results_due[$];
   int mismatches = 0;
   int bytes_sent = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_stall_left = 0;
   int quiet_cycles = 0;
   string cmd_pool = "GGGMMT";
   string field_pool = "XYZEFSPIJRNHKA*";

   gcode_line_char_parser #(
      .MAX_FRAC_DIGITS(FRAC_LIMIT),
      .MANTISSA_BITS(MANT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_field_letter(rsp_field_letter),
      .rsp_value_negative(rsp_value_negative),
      .rsp_value_mantissa(rsp_value_mantissa),
      .rsp_point_code(rsp_point_code),
      .rsp_seen_mask(rsp_seen_mask),
      .rsp_has_command(rsp_has_command),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int seen_position(input logic [7:0] c);
      case (c)
         "G": return gclp_pkg::SEEN_G;
         "M": return gclp_pkg::SEEN_M;
         "X": return gclp_pkg::SEEN_X;
         "Y": return gclp_pkg::SEEN_Y;
         "Z": return gclp_pkg::SEEN_Z;
         "E": return gclp_pkg::SEEN_E;
         "F": return gclp_pkg::SEEN_F;
         "S": return gclp_pkg::SEEN_S;
         "P": return gclp_pkg::SEEN_P;
         "T": return gclp_pkg::SEEN_T;
         "I": return arc_mode ? gclp_pkg::SEEN_I : -1;
         "J": return arc_mode ? gclp_pkg::SEEN_J : -1;
         "R": return arc_mode ? gclp_pkg::SEEN_R : -1;
         default: return -1;
      endcase
   endfunction

   task automatic clear_number();
      num_negative = 1'b0;
      num_mantissa = '0;
      frac_count = '0;
   endtask

   // Advances the predicted state by one character and queues what it emits.
   task automatic parse_char(input logic [7:0] raw);
      logic [7:0] c;
      logic is_digit;
      int pos;
      int n;
      parse_result_type r;
      c = raw;
      n = 0;
      if (!in_text && c >= gclp_pkg::CHAR_LOW_A && c <= gclp_pkg::CHAR_LOW_Z)
         c = c & ~gclp_pkg::CASE_BIT;
      if (!in_text) begin
         is_digit = (c >= gclp_pkg::CHAR_ZERO && c <= gclp_pkg::CHAR_NINE);
         if (open_letter != 8'd0 && !is_digit && c != gclp_pkg::CHAR_POINT) begin
            pos = seen_position(open_letter);
            if (pos >= 0 && pos != gclp_pkg::SEEN_T) begin
               r = '0;
               r.letter = open_letter[6:0];
               r.negative = num_negative;
               r.mantissa = num_mantissa;
               r.point = frac_count[2:0];
               results_due.push_back(r);
               n++;
               // A completed M117 turns what follows into free text until a ']' or the line end.
               if (open_letter[6:0] == gclp_pkg::CHAR_M &&
                   num_mantissa == gclp_pkg::M_TEXT_CODE) in_text = 1'b1;
            end
         end
         if ((c >= gclp_pkg::CHAR_UP_A && c <= gclp_pkg::CHAR_UP_Z) ||
             c == gclp_pkg::CHAR_STAR) begin
            open_letter = c;
            clear_number();
         end
         if (is_digit) begin
            if (frac_count < FRAC_LIMIT + 1) begin
               num_mantissa = num_mantissa * 32'd10 + 32'(c - gclp_pkg::CHAR_ZERO);
               if (frac_count != 0) frac_count = frac_count + 1'b1;
            end
         end else begin
            pos = seen_position(c);
            if (pos >= 0) begin
               seen_flags[pos] = 1'b1;
            end else if (c == gclp_pkg::CHAR_LBRACK || c == gclp_pkg::CHAR_SEMI) begin
               in_text = 1'b1;
            end else if (c == gclp_pkg::CHAR_MINUS) begin
               num_negative = 1'b1;
               num_mantissa = '0;
               frac_count = '0;
            end else if (c == gclp_pkg::CHAR_POINT && frac_count == 0) begin
               frac_count = 4'd1;
            end
         end
      end else if (c == gclp_pkg::CHAR_RBRACK) begin
         in_text = 1'b0;
      end
      if (c == gclp_pkg::CHAR_LF || c == gclp_pkg::CHAR_CR) begin
         r = '0;
         r.kind = 1'b1;
         r.seen = seen_flags;
         r.command = |(seen_flags & gclp_pkg::SEEN_CMD_MASK);
         results_due.push_back(r);
         n++;
         seen_flags = '0;
         in_text = 1'b0;
         open_letter = '0;
         clear_number();
      end
      if (n > 0) results_due[$].last_of_run = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   task automatic check_result();
      parse_result_type want;
      if (results_due.size() == 0) begin
         report_mismatch("result with none outstanding", 32'd0, 32'd0);
         return;
      end
      want = results_due.pop_front();
      if (rsp_result_kind !== want.kind)
         report_mismatch("result_kind", 32'(want.kind), 32'(rsp_result_kind));
      if (rsp_field_letter !== want.letter)
         report_mismatch("field_letter", 32'(want.letter), 32'(rsp_field_letter));
      if (rsp_value_negative !== want.negative)
         report_mismatch("value_negative", 32'(want.negative), 32'(rsp_value_negative));
      if (rsp_value_mantissa !== want.mantissa)
         report_mismatch("value_mantissa", want.mantissa, rsp_value_mantissa);
      if (rsp_point_code !== want.point)
         report_mismatch("point_code", 32'(want.point), 32'(rsp_point_code));
      if (rsp_seen_mask !== want.seen)
         report_mismatch("seen_mask", 32'(want.seen), 32'(rsp_seen_mask));
      if (rsp_has_command !== want.command)
         report_mismatch("has_command", 32'(want.command), 32'(rsp_has_command));
      if (rsp_last_of_run !== want.last_of_run)
         report_mismatch("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
   endtask

   // Result side: check every transfer and stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         rsp_stall_left = $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("gcode_line_char_parser verification failed");
            $finish;
         end
      end
   end

   // Valid is left high after a transfer; callers that wait lower it first.
   task automatic send_byte(input logic [7:0] b);
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_char(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_arc_mode(input logic value);
      wait_until_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      arc_mode = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_letter(input logic [7:0] c);
      if (c != gclp_pkg::CHAR_STAR && $urandom_range(3) == 0)
         send_byte(c | gclp_pkg::CASE_BIT);
      else send_byte(c);
   endtask

   task automatic send_number();
      int int_digits;
      if ($urandom_range(3) == 0) send_byte(gclp_pkg::CHAR_MINUS);
      int_digits = ($urandom_range(19) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
      repeat (int_digits) send_byte(8'(gclp_pkg::CHAR_ZERO + $urandom_range(9)));
      if ($urandom_range(2) == 0) begin
         send_byte(gclp_pkg::CHAR_POINT);
         repeat ($urandom_range(0, 7)) send_byte(8'(gclp_pkg::CHAR_ZERO + $urandom_range(9)));
      end
   endtask

   task automatic send_free_text(input int count);
      repeat (count) send_byte(8'($urandom_range(32, 126)));
   endtask

   task automatic send_random_line();
      if ($urandom_range(9) != 0) begin
         send_letter(cmd_pool[$urandom_range(cmd_pool.len() - 1)]);
         if ($urandom_range(7) == 0) begin
            send_text("M117 ");
            send_free_text($urandom_range(0, 8));
         end else begin
            send_number();
         end
      end
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(1) == 0) send_byte(" ");
         send_letter(field_pool[$urandom_range(field_pool.len() - 1)]);
         send_number();
      end
      case ($urandom_range(5))
         0: begin
            send_byte(gclp_pkg::CHAR_SEMI);
            send_free_text($urandom_range(0, 6));
         end
         1: begin
            send_byte(gclp_pkg::CHAR_LBRACK);
            send_free_text($urandom_range(0, 6));
            send_byte(gclp_pkg::CHAR_RBRACK);
            send_letter(field_pool[$urandom_range(field_pool.len() - 1)]);
            send_number();
         end
         default: ;
      endcase
      case ($urandom_range(3))
         0: begin
            send_byte(gclp_pkg::CHAR_CR);
            send_byte(gclp_pkg::CHAR_LF);
         end
         1: send_byte(gclp_pkg::CHAR_CR);
         default: send_byte(gclp_pkg::CHAR_LF);
      endcase
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic test_field_parsing();
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      // Lower case, a capped fraction, an unhandled star field and T on one line.
      send_text("g12x-3.14159*7t\r");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(gclp_pkg::CHAR_LF);
   endtask

   task automatic test_text_modes();
      // M117 then a comment; the bracket ends free text, z opens a field and the line feed closes the line.
      send_text("M117;x]z\n");
   endtask

   task automatic test_arc_letters();
      set_arc_mode(1'b1);
      send_text("i-5\n");
   endtask

   task automatic test_random_traffic();
      int phase_end;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               set_arc_mode(1'b1);
               req_gap_pct = 25;
               rsp_stall_pct = 25;
            end
            1: begin
               set_arc_mode(1'b0);
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
            2: begin
               set_arc_mode(1'($urandom_range(1)));
               req_gap_pct = 8;
               rsp_stall_pct = 50;
            end
            3: begin
               set_arc_mode(1'b1);
               req_gap_pct = 50;
               rsp_stall_pct = 8;
            end
            default: begin
               set_arc_mode(1'b0);
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         phase_end = bytes_sent + 135;
         while (bytes_sent < phase_end) begin
            if ($urandom_range(9) < 8) send_random_line();
            else send_noise();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_text_byte = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_field_parsing();
      test_text_modes();
      test_arc_letters();
      test_random_traffic();
      wait_until_drained();
      if (mismatches == 0) begin
         $display("gcode_line_char_parser verification clean");
      end else begin
         $display("gcode_line_char_parser verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
